FILE: rtl/command_frame_builder_checker_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_BUILDER_CHECKER_MACROS_SVH
`define COMMAND_FRAME_BUILDER_CHECKER_MACROS_SVH

// Same-cycle implication
`define CFBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfbc assertion failed");

// Next-cycle implication
`define CFBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfbc assertion failed");

`endif

FILE: rtl/cfbc_pkg.sv
// ----------------------------------------------------------------------------
// cfbc_pkg
// Types and codes shared by the command frame builder and checker.
// ----------------------------------------------------------------------------
package cfbc_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_REPLY   = 2'd2;

  // Result item kinds
  localparam logic [1:0] OUT_FRAME = 2'd0;
  localparam logic [1:0] OUT_DATA  = 2'd1;
  localparam logic [1:0] OUT_DONE  = 2'd2;

  // Completion status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SIZE     = 3'd1;
  localparam logic [2:0] ST_CHECKSUM = 3'd2;
  localparam logic [2:0] ST_SEQUENCE = 3'd3;
  localparam logic [2:0] ST_DEVICE   = 3'd4;

  // Most results one input item can cause, and the width of a count of them
  localparam int MaxResults = 6;
  localparam int CntW       = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] mailbox;
    logic [7:0] command;
    logic [7:0] payload_count;
    logic [7:0] reply_count;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic [7:0] device_status;
    logic       last;
  } result_t;

  typedef struct packed {
    result_t [MaxResults-1:0] res;
    logic [CntW-1:0]          cnt;
  } batch_t;

endpackage

FILE: rtl/cfbc_in_if.sv
// ----------------------------------------------------------------------------
// cfbc_in_if
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface cfbc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] mailbox;
  logic [7:0] command;
  logic [7:0] payload_count;
  logic [7:0] reply_count;
  logic [7:0] data_byte;

  modport source (
    output valid, kind, mailbox, command, payload_count, reply_count, data_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, mailbox, command, payload_count, reply_count, data_byte,
    output ready
  );
endinterface

FILE: rtl/cfbc_out_if.sv
// ----------------------------------------------------------------------------
// cfbc_out_if
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface cfbc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic [7:0] device_status;
  logic       last;

  modport source (
    output valid, out_kind, out_byte, status, device_status, last,
    input  ready
  );
  modport sink (
    input  valid, out_kind, out_byte, status, device_status, last,
    output ready
  );
endinterface

FILE: rtl/cfbc_engine.sv
// ----------------------------------------------------------------------------
// cfbc_engine
// Transaction state and per-item frame build / reply check logic.
// ----------------------------------------------------------------------------
module cfbc_engine #(
  parameter int FRAME_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  cfbc_pkg::in_item_t item,
  output cfbc_pkg::batch_t  batch
);
  import cfbc_pkg::*;

  localparam int PayloadMax = FRAME_BYTES - 6;
  localparam int ReplyMax   = FRAME_BYTES - 5;

  typedef enum logic [1:0] {PH_IDLE, PH_SEND, PH_RECV} phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  seq_counter, seq_counter_next;
  logic [15:0] running_sum, running_sum_next;
  logic [8:0]  byte_position, byte_position_next;
  logic [7:0]  payload_left, payload_left_next;
  logic [7:0]  reply_expected, reply_expected_next;
  logic [7:0]  sent_sequence, sent_sequence_next;
  logic [7:0]  recv_hi, recv_hi_next;
  logic        seq_ok, seq_ok_next;
  logic [7:0]  reply_status_byte, reply_status_byte_next;

  logic [15:0] sum_start, sum_add;
  logic [15:0] csum_start, csum_add;
  logic [8:0]  data_end;
  logic [7:0]  left_dec;
  logic [2:0]  done_status;
  logic        size_err;

  function automatic result_t mk(logic [1:0] k, logic [7:0] b, logic [2:0] st,
                                 logic [7:0] dev, logic lst);
    result_t r;
    r.out_kind      = k;
    r.out_byte      = b;
    r.status        = st;
    r.device_status = dev;
    r.last          = lst;
    return r;
  endfunction

  // Odd positions weigh as the high byte, even ones as the low byte
  function automatic logic [15:0] term(logic odd, logic [7:0] b);
    return odd ? {b, 8'h00} : {8'h00, b};
  endfunction

  always_comb begin
    size_err   = ({1'b0, item.payload_count} > 9'(PayloadMax)) ||
                 ({1'b0, item.reply_count} > 9'(ReplyMax));
    sum_start  = {item.mailbox, 8'h00} + {8'h00, item.command} + {seq_counter, 8'h00};
    csum_start = ~sum_start;
    sum_add    = running_sum + term(byte_position[0], item.data_byte);
    csum_add   = ~sum_add;
    left_dec   = payload_left - 8'd1;
    data_end   = 9'd3 + {1'b0, reply_expected};
    if ({recv_hi, item.data_byte} != ~running_sum) begin
      done_status = ST_CHECKSUM;
    end else if (!seq_ok) begin
      done_status = ST_SEQUENCE;
    end else if (reply_status_byte != 8'h00) begin
      done_status = ST_DEVICE;
    end else begin
      done_status = ST_OK;
    end
  end

  always_comb begin
    phase_next             = phase;
    seq_counter_next       = seq_counter;
    running_sum_next       = running_sum;
    byte_position_next     = byte_position;
    payload_left_next      = payload_left;
    reply_expected_next    = reply_expected;
    sent_sequence_next     = sent_sequence;
    recv_hi_next           = recv_hi;
    seq_ok_next            = seq_ok;
    reply_status_byte_next = reply_status_byte;
    batch                  = '0;

    unique case (item.kind)
      KIND_START: begin
        if (size_err) begin
          phase_next   = PH_IDLE;
          batch.res[0] = mk(OUT_DONE, 8'h00, ST_SIZE, 8'h00, 1'b1);
          batch.cnt    = CntW'(1);
        end else begin
          sent_sequence_next  = seq_counter;
          seq_counter_next    = seq_counter + 8'd1;
          payload_left_next   = item.payload_count;
          reply_expected_next = item.reply_count;
          running_sum_next    = sum_start;
          byte_position_next  = 9'd4;
          phase_next          = PH_SEND;
          batch.res[0] = mk(OUT_FRAME, item.payload_count + 8'd5, ST_OK, 8'h00, 1'b0);
          batch.res[1] = mk(OUT_FRAME, item.mailbox, ST_OK, 8'h00, 1'b0);
          batch.res[2] = mk(OUT_FRAME, item.command, ST_OK, 8'h00, 1'b0);
          batch.res[3] = mk(OUT_FRAME, seq_counter, ST_OK, 8'h00, 1'b0);
          batch.cnt    = CntW'(4);
          if (item.payload_count == 8'h00) begin
            // Empty payload: close the frame right away
            batch.res[4]           = mk(OUT_FRAME, csum_start[15:8], ST_OK, 8'h00, 1'b0);
            batch.res[5]           = mk(OUT_FRAME, csum_start[7:0], ST_OK, 8'h00, 1'b1);
            batch.cnt              = CntW'(6);
            phase_next             = PH_RECV;
            byte_position_next     = 9'd0;
            running_sum_next       = 16'h0000;
            recv_hi_next           = 8'h00;
            seq_ok_next            = 1'b0;
            reply_status_byte_next = 8'h00;
          end
        end
      end
      KIND_PAYLOAD: begin
        if (phase == PH_SEND) begin
          running_sum_next   = sum_add;
          byte_position_next = byte_position + 9'd1;
          payload_left_next  = left_dec;
          batch.res[0]       = mk(OUT_FRAME, item.data_byte, ST_OK, 8'h00, 1'b0);
          batch.cnt          = CntW'(1);
          if (left_dec == 8'h00) begin
            batch.res[1]           = mk(OUT_FRAME, csum_add[15:8], ST_OK, 8'h00, 1'b0);
            batch.res[2]           = mk(OUT_FRAME, csum_add[7:0], ST_OK, 8'h00, 1'b1);
            batch.cnt              = CntW'(3);
            phase_next             = PH_RECV;
            byte_position_next     = 9'd0;
            running_sum_next       = 16'h0000;
            recv_hi_next           = 8'h00;
            seq_ok_next            = 1'b0;
            reply_status_byte_next = 8'h00;
          end
        end
      end
      KIND_REPLY: begin
        if (phase == PH_RECV) begin
          if (byte_position == 9'd0) begin
            // Length byte: skip, not checked
            byte_position_next = 9'd1;
          end else if (byte_position == 9'd1) begin
            seq_ok_next        = (item.data_byte == sent_sequence);
            running_sum_next   = sum_add;
            byte_position_next = byte_position + 9'd1;
          end else if (byte_position == 9'd2) begin
            reply_status_byte_next = item.data_byte;
            running_sum_next       = sum_add;
            byte_position_next     = byte_position + 9'd1;
          end else if (byte_position < data_end) begin
            running_sum_next   = sum_add;
            byte_position_next = byte_position + 9'd1;
            batch.res[0]       = mk(OUT_DATA, item.data_byte, ST_OK, 8'h00, 1'b0);
            batch.cnt          = CntW'(1);
          end else if (byte_position == data_end) begin
            recv_hi_next       = item.data_byte;
            byte_position_next = byte_position + 9'd1;
          end else begin
            batch.res[0]       = mk(OUT_DONE, 8'h00, done_status, reply_status_byte, 1'b1);
            batch.cnt          = CntW'(1);
            phase_next         = PH_IDLE;
            byte_position_next = 9'd0;
          end
        end
      end
      default: begin
        // Undefined kind: drop
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      seq_counter       <= '0;
      running_sum       <= '0;
      byte_position     <= '0;
      payload_left      <= '0;
      reply_expected    <= '0;
      sent_sequence     <= '0;
      recv_hi           <= '0;
      seq_ok            <= 1'b0;
      reply_status_byte <= '0;
    end else if (fire) begin
      phase             <= phase_next;
      seq_counter       <= seq_counter_next;
      running_sum       <= running_sum_next;
      byte_position     <= byte_position_next;
      payload_left      <= payload_left_next;
      reply_expected    <= reply_expected_next;
      sent_sequence     <= sent_sequence_next;
      recv_hi           <= recv_hi_next;
      seq_ok            <= seq_ok_next;
      reply_status_byte <= reply_status_byte_next;
    end
  end

endmodule

FILE: rtl/command_frame_builder_checker.sv
// ----------------------------------------------------------------------------
// command_frame_builder_checker
// Builds bridge request frames and checks the device replies.
// ----------------------------------------------------------------------------
//
//   channel | dir | carries
//   --------+-----+---------------------------------------------------------
//   req     | in  | start, request payload byte or reply byte from device
//   rsp     | out | frame byte to send, reply data byte or completion
//
// An accepted item is held in the input register, then the engine turns
// it into up to six results that load the result queue together, and the
// first result shows from there. Items flow one per cycle while rsp is
// ready, as long as each causes at most one result; an item that causes
// more waits while the queue drains one result per cycle.
// Synchronous reset clears all control state.
// A stalled rsp holds the queue head and backs pressure up into req.ready.
// ----------------------------------------------------------------------------
module command_frame_builder_checker #(
  parameter int FRAME_BYTES = 256
) (
  input logic        clk,
  input logic        rst,
  cfbc_in_if.sink    req,
  cfbc_out_if.source rsp
);
  import cfbc_pkg::*;

  // Input register
  in_item_t in_item;
  logic     in_vld;

  // Result queue: loaded whole, drained one result per cycle while rsp is ready
  result_t         res_buf [MaxResults];
  logic [CntW-1:0] head;
  logic [CntW-1:0] res_cnt;

  batch_t batch;
  logic   fire;
  logic   rsp_fire;

  // Process the held item once the queue is empty or empties this cycle
  assign rsp_fire  = rsp.valid && rsp.ready;
  assign fire      = in_vld &&
                     ((res_cnt == CntW'(0)) || ((res_cnt == CntW'(1)) && rsp.ready));
  assign req.ready = !in_vld || fire;

  cfbc_engine #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_item),
    .batch(batch)
  );

  // Hold the incoming item; drop the valid once processed
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_vld <= 1'b1;
    end else if (fire) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.kind          <= req.kind;
      in_item.mailbox       <= req.mailbox;
      in_item.command       <= req.command;
      in_item.payload_count <= req.payload_count;
      in_item.reply_count   <= req.reply_count;
      in_item.data_byte     <= req.data_byte;
    end
  end

  // Queue control: load a new batch, or advance past the delivered head
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      res_cnt <= '0;
    end else if (fire) begin
      head    <= '0;
      res_cnt <= batch.cnt;
    end else if (rsp_fire) begin
      head    <= head + CntW'(1);
      res_cnt <= res_cnt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < MaxResults; i++) begin
        res_buf[i] <= batch.res[i];
      end
    end
  end

  assign rsp.valid         = (res_cnt != CntW'(0));
  assign rsp.out_kind      = res_buf[head].out_kind;
  assign rsp.out_byte      = res_buf[head].out_byte;
  assign rsp.status        = res_buf[head].status;
  assign rsp.device_status = res_buf[head].device_status;
  assign rsp.last          = res_buf[head].last;

`include "command_frame_builder_checker_macros.svh"

  // A completion always closes its transaction
  `CFBC_ASSERT_NOW(a_done_last, rsp.valid && (rsp.out_kind == OUT_DONE), rsp.last)
  // The queue never holds more than one batch
  `CFBC_ASSERT_NOW(a_cnt_bound, 1'b1, ((CntW+1)'(head) + (CntW+1)'(res_cnt)) <= (CntW+1)'(MaxResults))
  // A processed item that causes results shows one next cycle
  `CFBC_ASSERT_NEXT(a_batch_shown, fire && (batch.cnt != CntW'(0)), rsp.valid)

endmodule
